/* sv/lifo_stack_with_pick_and_remove_assert.svh */
// Assertion macros shared by the stack RTL.
`ifndef LIFO_STACK_WITH_PICK_AND_REMOVE_ASSERT_SVH
`define LIFO_STACK_WITH_PICK_AND_REMOVE_ASSERT_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define LSPR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lspr assertion failed");
// Antecedent implies consequent in the next cycle.
`define LSPR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lspr assertion failed");
`else
`define LSPR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define LSPR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/lspr_pkg.sv */
`timescale 1ns / 1ps

package lspr_pkg;

   localparam int DATA_W  = 64;
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 6;
   localparam int CAP_W   = 7;
   localparam int STAT_W  = 2;
   localparam int ECNT_W  = 7;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PICK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [DATA_W-1:0] push_value;
      logic [IDX_W-1:0]         depth_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [STAT_W-1:0]        status;
      logic [ECNT_W-1:0]        entry_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_SHIFT
   } state_type;

endpackage

/* sv/lspr_ram.sv */
`timescale 1ns / 1ps

module lspr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/lifo_stack_with_pick_and_remove.sv */
`timescale 1ns / 1ps
// Channel   | Ports                          | Handshake
// ----------+--------------------------------+--------------------------------
// request   | start, busy, req_payload       | taken when start & !busy
// response  | rsp_valid, rsp_payload         | one-cycle strobe, no backpressure
// config    | csr_wr_en, csr_wr_data         | capacity written when csr_wr_en
//
// Busy per request: push, clear, unused codes and errors end in ST_EXEC; pop,
// peek, pick add ST_READ (one stack RAM read); remove adds ST_READ and, for a
// nonzero depth_index, ST_SHIFT, one entry moved per cycle via the single RAM
// write port and shared address adder; the response strobes when busy first drops.
// Reset is synchronous and empties the stack; capacity resets to 64.
// The receiver cannot stall; a new request can be taken while a response shows.

module lifo_stack_with_pick_and_remove #(
   parameter int DEPTH      = 64,
   parameter int CELL_WIDTH = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  lspr_pkg::req_type                       req_payload,
   output logic                                    rsp_valid,
   output lspr_pkg::rsp_type                       rsp_payload,
   input  logic                                    csr_wr_en,
   input  logic [lspr_pkg::CAP_W-1:0]              csr_wr_data
);

`include "lifo_stack_with_pick_and_remove_assert.svh"

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int UW    = (CNT_W > lspr_pkg::CAP_W) ? CNT_W : lspr_pkg::CAP_W;

   lspr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [lspr_pkg::CAP_W-1:0] cap_ff;
   lspr_pkg::req_type   req_ff;
   logic [AW-1:0]       wr_ff, wr_in;
   logic [AW-1:0]       rdp_ff, rdp_in;
   logic [lspr_pkg::IDX_W-1:0] left_ff, left_in;
   logic signed [lspr_pkg::DATA_W-1:0] hold_ff, hold_in;
   lspr_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [CELL_WIDTH-1:0] ram_wdata, ram_rdata;

   // shared address/compare unit: a + b, or a - b when au_sub
   logic [UW-1:0] au_a, au_b, au_res;
   logic          au_sub, au_carry;
   logic [UW:0]   au_sum;

   logic [UW-1:0] count_ext, limit;
   logic signed [lspr_pkg::DATA_W-1:0] rd_sext, push_sext;
   logic accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != lspr_pkg::ST_IDLE);
   assign count_ext = UW'(count_ff);
   assign limit     = (UW'(cap_ff) < UW'(DEPTH)) ? UW'(cap_ff) : UW'(DEPTH);
   assign rd_sext   = lspr_pkg::DATA_W'($signed(ram_rdata));
   assign push_sext = lspr_pkg::DATA_W'($signed(req_ff.push_value[CELL_WIDTH-1:0]));

   assign au_sum   = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (UW+1)'(au_sub);
   assign au_carry = au_sum[UW];
   assign au_res   = au_sum[UW-1:0];

   lspr_ram #(
      .WIDTH (CELL_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer: next state, datapath controls, response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      wr_in        = wr_ff;
      rdp_in       = rdp_ff;
      left_in      = left_ff;
      hold_in      = hold_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = wr_ff;
      ram_wdata    = req_ff.push_value[CELL_WIDTH-1:0];
      ram_raddr    = '0;
      au_a         = count_ext;
      au_b         = '0;
      au_sub       = 1'b1;

      case (state_ff)
         lspr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = lspr_pkg::ST_EXEC;
            end
         end

         lspr_pkg::ST_EXEC: begin
            rsp_in.data   = '0;
            rsp_in.status = lspr_pkg::STAT_OK;
            state_in      = lspr_pkg::ST_IDLE;
            rsp_valid_in  = 1'b1;
            case (req_ff.command)
               lspr_pkg::CMD_PUSH: begin
                  au_b = limit;
                  if (au_carry) begin
                     rsp_in.status = lspr_pkg::STAT_OVERFLOW;
                  end else begin
                     ram_we      = 1'b1;
                     ram_waddr   = count_ext[AW-1:0];
                     rsp_in.data = push_sext;
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               lspr_pkg::CMD_POP, lspr_pkg::CMD_PEEK: begin
                  au_b = UW'(1);
                  if (!au_carry) begin
                     rsp_in.status = lspr_pkg::STAT_EMPTY;
                  end else begin
                     ram_raddr    = au_res[AW-1:0];
                     wr_in        = au_res[AW-1:0];
                     state_in     = lspr_pkg::ST_READ;
                     rsp_valid_in = 1'b0;
                  end
               end
               lspr_pkg::CMD_PICK, lspr_pkg::CMD_REMOVE: begin
                  // count - (index + 1) borrows when index is not below count
                  au_b = UW'(req_ff.depth_index) + UW'(1);
                  if (!au_carry) begin
                     rsp_in.status = lspr_pkg::STAT_RANGE;
                  end else begin
                     ram_raddr    = au_res[AW-1:0];
                     wr_in        = au_res[AW-1:0];
                     state_in     = lspr_pkg::ST_READ;
                     rsp_valid_in = 1'b0;
                  end
               end
               lspr_pkg::CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
               end
            endcase
            rsp_in.entry_count = lspr_pkg::ECNT_W'(count_in);
         end

         lspr_pkg::ST_READ: begin
            rsp_in.data   = rd_sext;
            rsp_in.status = lspr_pkg::STAT_OK;
            hold_in       = rd_sext;
            au_a          = UW'(wr_ff);
            au_b          = UW'(1);
            au_sub        = 1'b0;
            if (req_ff.command == lspr_pkg::CMD_REMOVE && req_ff.depth_index != '0) begin
               // entries above the removed one move down, one per cycle
               ram_raddr = au_res[AW-1:0];
               rdp_in    = au_res[AW-1:0];
               left_in   = req_ff.depth_index;
               state_in  = lspr_pkg::ST_SHIFT;
            end else begin
               if (req_ff.command != lspr_pkg::CMD_PEEK &&
                   req_ff.command != lspr_pkg::CMD_PICK) begin
                  count_in = count_ff - CNT_W'(1);
               end
               rsp_valid_in = 1'b1;
               state_in     = lspr_pkg::ST_IDLE;
            end
            rsp_in.entry_count = lspr_pkg::ECNT_W'(count_in);
         end

         lspr_pkg::ST_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ff;
            ram_wdata = ram_rdata;
            wr_in     = rdp_ff;
            au_a      = UW'(rdp_ff);
            au_b      = UW'(1);
            au_sub    = 1'b0;
            ram_raddr = au_res[AW-1:0];
            rdp_in    = au_res[AW-1:0];
            left_in   = left_ff - lspr_pkg::IDX_W'(1);
            if (left_ff == lspr_pkg::IDX_W'(1)) begin
               count_in           = count_ff - CNT_W'(1);
               rsp_in.data        = hold_ff;
               rsp_in.status      = lspr_pkg::STAT_OK;
               rsp_in.entry_count = lspr_pkg::ECNT_W'(count_in);
               rsp_valid_in       = 1'b1;
               state_in           = lspr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lspr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lspr_pkg::ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= lspr_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      wr_ff   <= wr_in;
      rdp_ff  <= rdp_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `LSPR_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `LSPR_ASSERT_NEXT(a_accept_exec, clock, reset, accept, state_ff == lspr_pkg::ST_EXEC)
   `LSPR_ASSERT_NEXT(a_done_rsp, clock, reset,
      state_ff != lspr_pkg::ST_IDLE && state_in == lspr_pkg::ST_IDLE, rsp_valid_ff)
   `LSPR_ASSERT_SAME(a_err_zero, clock, reset,
      rsp_valid_ff && rsp_ff.status != lspr_pkg::STAT_OK, rsp_ff.data == '0)
   `LSPR_ASSERT_SAME(a_shift_left, clock, reset,
      state_ff == lspr_pkg::ST_SHIFT, left_ff != '0)

endmodule
